// File: rtl/core/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver package
// Shared constants, result event codes and the command and status bundles
// that join the receiver controller to its datapath.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    // Default largest payload, in bytes, that a frame may carry.
    localparam int MAX_PAYLOAD_DEF = 32;

    // Field widths fixed by the link format.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int COUNT_W  = 32;
    localparam int CRC_W    = 16;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W = 4;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Sync byte reset values.
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd1;

    // Result event codes.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_HEADER  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_CRC_ERR = 3'd3,
        EV_OVERRUN = 3'd4
    } crcfr_event_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         load_byte;
        logic         store_len_lo;
        logic         store_len;
        logic         store_type;
        logic         store_payload;
        logic         crc_shift;
        logic         store_crc_lo;
        logic         inc_ok;
        logic         inc_crc_err;
        logic         inc_overrun;
        logic         clear_idx;
        logic         rd_issue;
        logic         out_load;
        crcfr_event_t out_event;
        logic         out_last;
    } crcfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sync_first;
        logic is_sync_second;
        logic len_too_big;
        logic len_zero;
        logic payload_done;
        logic crc_match;
        logic pay_last;
        logic slot_free;
    } crcfr_stat_t;

endpackage

// File: rtl/core/crcfr_ctrl.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver controller
// Tracks the frame parse phase and sequences each received word through
// decode, the bit-serial CRC update and the emission of its results.
// ----------------------------------------------------------------------------
module crcfr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  crcfr_pkg::crcfr_stat_t stat,
    output crcfr_pkg::crcfr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CRC,
        S_EMIT,
        S_READ,
        S_PAY
    } state_t;

    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN0,
        PH_LEN1,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CRC0,
        PH_CRC1
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [2:0]              bit_cnt_reg, bit_cnt_next;
    crcfr_pkg::crcfr_event_t ev_reg, ev_next;
    logic                    last_reg, last_next;

    // A new word is taken only between items.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        ev_next      = ev_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.out_event = crcfr_pkg::EV_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                ev_next    = crcfr_pkg::EV_NONE;
                last_next  = 1'b1;
                state_next = S_EMIT;
                case (phase_reg)
                    PH_SYNC0:
                    begin
                        if (stat.is_sync_first)
                        begin
                            phase_next = PH_SYNC1;
                        end
                    end
                    PH_SYNC1:
                    begin
                        // A match on the second sync byte wins over the first.
                        if (stat.is_sync_second)
                        begin
                            phase_next = PH_LEN0;
                        end
                        else if (!stat.is_sync_first)
                        begin
                            phase_next = PH_SYNC0;
                        end
                    end
                    PH_LEN0:
                    begin
                        cmd.store_len_lo = 1'b1;
                        phase_next       = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        if (stat.len_too_big)
                        begin
                            cmd.inc_overrun = 1'b1;
                            ev_next         = crcfr_pkg::EV_OVERRUN;
                            phase_next      = PH_SYNC0;
                        end
                        else
                        begin
                            cmd.store_len = 1'b1;
                            phase_next    = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        cmd.store_type = 1'b1;
                        phase_next     = stat.len_zero ? PH_CRC0 : PH_PAYLOAD;
                        bit_cnt_next   = '0;
                        state_next     = S_CRC;
                    end
                    PH_PAYLOAD:
                    begin
                        cmd.store_payload = 1'b1;
                        if (stat.payload_done)
                        begin
                            phase_next = PH_CRC0;
                        end
                        bit_cnt_next = '0;
                        state_next   = S_CRC;
                    end
                    PH_CRC0:
                    begin
                        cmd.store_crc_lo = 1'b1;
                        phase_next       = PH_CRC1;
                    end
                    PH_CRC1:
                    begin
                        cmd.clear_idx = 1'b1;
                        phase_next    = PH_SYNC0;
                        if (stat.crc_match)
                        begin
                            cmd.inc_ok = 1'b1;
                            ev_next    = crcfr_pkg::EV_HEADER;
                            last_next  = stat.len_zero;
                        end
                        else
                        begin
                            cmd.inc_crc_err = 1'b1;
                            ev_next         = crcfr_pkg::EV_CRC_ERR;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SYNC0;
                    end
                endcase
            end

            // One CRC bit per cycle, eight bits per word.
            S_CRC:
            begin
                cmd.crc_shift = 1'b1;
                bit_cnt_next  = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = S_EMIT;
                end
            end

            // Single result, or the header of a good frame.
            S_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_event = ev_reg;
                    cmd.out_last  = last_reg;
                    if (ev_reg == crcfr_pkg::EV_HEADER && !last_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_PAY;
            end

            // Payload results, one buffer read each.
            S_PAY:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_event = crcfr_pkg::EV_PAYLOAD;
                    cmd.out_last  = stat.pay_last;
                    state_next    = stat.pay_last ? S_IDLE : S_READ;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_SYNC0;
            bit_cnt_reg <= '0;
            ev_reg      <= crcfr_pkg::EV_NONE;
            last_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            ev_reg      <= ev_next;
            last_reg    <= last_next;
        end
    end

    // A result is only loaded into a free output slot.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.slot_free)
        else $error("result loaded into occupied output slot");

    // The CRC loop only runs after a type or payload word.
    a_crc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC) |-> (phase_reg == PH_PAYLOAD || phase_reg == PH_CRC0))
        else $error("CRC update outside type or payload");

    // An accepted word is decoded in the next cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted word not decoded");

endmodule

// File: rtl/core/crcfr_dp.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver datapath
// Holds the sync registers, frame fields, running CRC, payload buffer,
// frame counters and the output result register.
// ----------------------------------------------------------------------------
module crcfr_dp
#(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crcfr_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic [crcfr_pkg::BYTE_W-1:0]        rx_byte,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [crcfr_pkg::EVENT_W-1:0]       event_res,
    output logic [crcfr_pkg::BYTE_W-1:0]        msg_type,
    output logic [crcfr_pkg::LEN_W-1:0]         frame_len,
    output logic [crcfr_pkg::BYTE_W-1:0]        data_byte,
    output logic                                last,
    output logic [crcfr_pkg::COUNT_W-1:0]       frames_ok_count,
    output logic [crcfr_pkg::COUNT_W-1:0]       crc_error_count,
    output logic [crcfr_pkg::COUNT_W-1:0]       overrun_count,
    input  crcfr_pkg::crcfr_cmd_t               cmd,
    output crcfr_pkg::crcfr_stat_t              stat
);

    localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BW = crcfr_pkg::BYTE_W;
    localparam int LW = crcfr_pkg::LEN_W;
    localparam int CW = crcfr_pkg::COUNT_W;

    logic [BW-1:0] sync_first_reg, sync_second_reg;
    logic [BW-1:0] byte_reg;
    logic [BW-1:0] len_lo_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] idx_reg;
    logic [BW-1:0] type_reg;
    logic [BW-1:0] crc_lo_reg;
    logic [crcfr_pkg::CRC_W-1:0] crc_reg;
    logic [CW-1:0] ok_cnt_reg, err_cnt_reg, ovr_cnt_reg;
    logic [BW-1:0] rd_data_reg;
    logic [BW-1:0] store_mem [MAX_PAYLOAD];

    logic                  out_valid_reg;
    logic [crcfr_pkg::EVENT_W-1:0] out_event_reg;
    logic [BW-1:0]         out_type_reg;
    logic [LW-1:0]         out_len_reg;
    logic [BW-1:0]         out_data_reg;
    logic                  out_last_reg;
    logic [CW-1:0]         out_ok_reg, out_err_reg, out_ovr_reg;

    logic                  reported;

    // Status for the controller.
    assign stat.is_sync_first  = (byte_reg == sync_first_reg);
    assign stat.is_sync_second = (byte_reg == sync_second_reg);
    assign stat.len_too_big    = ({byte_reg, len_lo_reg} > (2*BW)'(MAX_PAYLOAD));
    assign stat.len_zero       = (len_reg == '0);
    assign stat.payload_done   = ((cnt_reg + LW'(1)) >= len_reg);
    assign stat.crc_match      = ({byte_reg, crc_lo_reg} == crc_reg);
    assign stat.pay_last       = (idx_reg == len_reg);
    assign stat.slot_free      = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= crcfr_pkg::SYNC_FIRST_RST;
            sync_second_reg <= crcfr_pkg::SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == crcfr_pkg::REG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_wdata;
            end
            else if (cfg_index == crcfr_pkg::REG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_wdata;
            end
        end
    end

    // Frame fields, buffer pointers and the running CRC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_lo_reg <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            type_reg   <= '0;
            crc_lo_reg <= '0;
            crc_reg    <= crcfr_pkg::CRC_INIT;
        end
        else
        begin
            if (cmd.store_len_lo)
            begin
                len_lo_reg <= byte_reg;
            end
            if (cmd.store_len)
            begin
                len_reg <= len_lo_reg[LW-1:0];
            end
            if (cmd.store_type)
            begin
                type_reg <= byte_reg;
                cnt_reg  <= '0;
                crc_reg  <= crcfr_pkg::CRC_INIT ^ {byte_reg, 8'h00};
            end
            if (cmd.store_payload)
            begin
                cnt_reg <= cnt_reg + LW'(1);
                crc_reg <= crc_reg ^ {byte_reg, 8'h00};
            end
            if (cmd.crc_shift)
            begin
                crc_reg <= crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY)
                                       : {crc_reg[14:0], 1'b0};
            end
            if (cmd.store_crc_lo)
            begin
                crc_lo_reg <= byte_reg;
            end
            if (cmd.clear_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                idx_reg <= idx_reg + LW'(1);
            end
        end
    end

    // Input word and payload buffer with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.store_payload)
        begin
            store_mem[cnt_reg[AddrW-1:0]] <= byte_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[idx_reg[AddrW-1:0]];
        end
    end

    // Frame counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_cnt_reg  <= '0;
            err_cnt_reg <= '0;
            ovr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.inc_ok)
            begin
                ok_cnt_reg <= ok_cnt_reg + CW'(1);
            end
            if (cmd.inc_crc_err)
            begin
                err_cnt_reg <= err_cnt_reg + CW'(1);
            end
            if (cmd.inc_overrun)
            begin
                ovr_cnt_reg <= ovr_cnt_reg + CW'(1);
            end
        end
    end

    // Frame fields appear only on frame-level events.
    assign reported = (cmd.out_event == crcfr_pkg::EV_HEADER) ||
                      (cmd.out_event == crcfr_pkg::EV_PAYLOAD) ||
                      (cmd.out_event == crcfr_pkg::EV_CRC_ERR);

    // Output result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_event_reg <= cmd.out_event;
            out_type_reg  <= reported ? type_reg : '0;
            out_len_reg   <= reported ? len_reg : '0;
            out_data_reg  <= (cmd.out_event == crcfr_pkg::EV_PAYLOAD) ? rd_data_reg : '0;
            out_last_reg  <= cmd.out_last;
            out_ok_reg    <= ok_cnt_reg;
            out_err_reg   <= err_cnt_reg;
            out_ovr_reg   <= ovr_cnt_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = out_event_reg;
    assign msg_type        = out_type_reg;
    assign frame_len       = out_len_reg;
    assign data_byte       = out_data_reg;
    assign last            = out_last_reg;
    assign frames_ok_count = out_ok_reg;
    assign crc_error_count = out_err_reg;
    assign overrun_count   = out_ovr_reg;

    // Payload writes stay inside the announced length.
    a_write_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_payload |-> (cnt_reg < len_reg))
        else $error("payload write beyond frame length");

    // Buffer reads stay inside the received payload.
    a_read_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (idx_reg < len_reg))
        else $error("payload read beyond frame length");

endmodule

// File: rtl/core/crc16_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver
// Receives a byte stream, finds sync/length/type frames, checks their
// CRC-16/CCITT-FALSE and reports each frame, with its payload when the CRC matches.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   rx_byte
//   out      output     out_valid / out_stall event_res .. overrun_count
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// One received word is handled at a time: each word passes decode and emit,
// and a type or payload word also passes the bit-serial CRC loop, one bit a cycle.
// A good frame then emits a header plus one result per payload byte, each
// a buffer read then an emit, paced by the single buffer read port.
// The output register frees the input side as soon as the last result is loaded;
// out_stall holds the block only while that register is full.
// Reset is asynchronous and active low; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_top
#(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crcfr_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [crcfr_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [crcfr_pkg::EVENT_W-1:0]       event_res,
    output logic [crcfr_pkg::BYTE_W-1:0]        msg_type,
    output logic [crcfr_pkg::LEN_W-1:0]         frame_len,
    output logic [crcfr_pkg::BYTE_W-1:0]        data_byte,
    output logic                                last,
    output logic [crcfr_pkg::COUNT_W-1:0]       frames_ok_count,
    output logic [crcfr_pkg::COUNT_W-1:0]       crc_error_count,
    output logic [crcfr_pkg::COUNT_W-1:0]       overrun_count
);

    crcfr_pkg::crcfr_cmd_t  cmd;
    crcfr_pkg::crcfr_stat_t stat;

    // Parse and sequencing control.
    crcfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Frame storage, CRC and result datapath.
    crcfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .rx_byte         (rx_byte),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .event_res       (event_res),
        .msg_type        (msg_type),
        .frame_len       (frame_len),
        .data_byte       (data_byte),
        .last            (last),
        .frames_ok_count (frames_ok_count),
        .crc_error_count (crc_error_count),
        .overrun_count   (overrun_count),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
